@@ design/gsna_pkg.sv @@
package gsna_pkg;

	localparam int GROUPS_DEF           = 4;
	localparam int ROUTERS_PER_GROUP_DEF = 4;
	localparam int NODES_PER_ROUTER_DEF = 4;

	localparam int COUNT_W  = 7;
	localparam int MASK_W   = 64;
	localparam int NODE_W   = 6;
	localparam int SPREAD_W = 5;

	// ceil division numerator: count + spread - 1, at most 127 + 30
	localparam int NUM_W     = 8;
	localparam int DIV_STEPS = NUM_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	typedef struct packed {
		logic load;
		logic div_step;
		logic scan_step;
		logic push_report;
		logic push_node;
	} gsna_cmd_t;

	typedef struct packed {
		logic div_done;
		logic scan_last;
		logic shortfall;
		logic grant_zero;
		logic last_node;
		logic out_free;
	} gsna_status_t;

endpackage

@@ design/gsna_ctrl.sv @@
module gsna_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gsna_pkg::gsna_status_t status,
	output gsna_pkg::gsna_cmd_t    cmd
);
	import gsna_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DIV    = 5'b00010,
		S_SCAN   = 5'b00100,
		S_REPORT = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_nx = S_REPORT;
				end
			end
			S_REPORT: begin
				// full grant with nodes goes to the per-node stream
				if (!status.shortfall && !status.grant_zero) begin
					state_nx = S_EMIT;
				end else if (status.out_free) begin
					cmd.push_report = 1'b1;
					state_nx        = S_IDLE;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.push_node = 1'b1;
					if (status.last_node) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/gsna_dp.sv @@
module gsna_dp #(
	parameter int GROUPS            = gsna_pkg::GROUPS_DEF,
	parameter int ROUTERS_PER_GROUP = gsna_pkg::ROUTERS_PER_GROUP_DEF,
	parameter int NODES_PER_ROUTER  = gsna_pkg::NODES_PER_ROUTER_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gsna_pkg::SPREAD_W-1:0]     cfg_wr_data,
	input  logic [gsna_pkg::COUNT_W-1:0]      requested_count,
	input  logic [gsna_pkg::MASK_W-1:0]       available_mask,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [gsna_pkg::NODE_W-1:0]       granted_node,
	output logic                              node_valid,
	output logic                              success,
	output logic                              last,
	input  gsna_pkg::gsna_cmd_t               cmd,
	output gsna_pkg::gsna_status_t            status
);
	import gsna_pkg::*;

	localparam int GS    = ROUTERS_PER_GROUP * NODES_PER_ROUTER;
	localparam int TOTAL = GROUPS * GS;
	localparam int CW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int SW    = (GS > 1) ? $clog2(GS) : 1;
	localparam int IDW   = (CW > NODE_W + 1) ? CW : NODE_W + 1;

	logic [SPREAD_W-1:0] group_spread_q;
	logic [SPREAD_W-1:0] div_q;
	logic [SPREAD_W-1:0] rem_q;
	logic [NUM_W-1:0]    num_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic [MASK_W-1:0]   avail_q;
	logic [COUNT_W-1:0]  remaining_q;
	logic [COUNT_W-1:0]  found_q;
	logic [CW-1:0]       cursor_q;
	logic [SW-1:0]       slot_q;
	logic [MASK_W-1:0]   gpick_q;
	logic [MASK_W-1:0]   grant_q;
	logic                out_valid_q;

	logic [SPREAD_W-1:0] spread_eff;
	logic [SPREAD_W:0]   rem_sh;
	logic                rem_ge;
	logic [COUNT_W-1:0]  need;
	logic [IDW-1:0]      cur_ext;
	logic                node_free;
	logic                take;
	logic [COUNT_W-1:0]  found_nx;
	logic [MASK_W-1:0]   pick_nx;
	logic                grp_end;
	logic [NODE_W-1:0]   low_idx;
	logic [MASK_W-1:0]   grant_clr;
	logic                out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_spread_q <= SPREAD_W'(1);
		end else if (cfg_wr_en) begin
			group_spread_q <= cfg_wr_data;
		end
	end

	assign spread_eff = (group_spread_q == '0) ? SPREAD_W'(1) : group_spread_q;

	// restoring divider, one quotient bit per step; quotient shifts into num_q
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, div_q});

	// quota is num_q once division is done
	assign need = ({1'b0, remaining_q} < num_q) ? remaining_q : num_q[COUNT_W-1:0];

	assign cur_ext   = IDW'(cursor_q);
	assign node_free = (cur_ext < IDW'(MASK_W)) && avail_q[cur_ext[NODE_W-1:0]];
	assign take      = node_free && (found_q < need);
	assign found_nx  = found_q + COUNT_W'(take);
	assign pick_nx   = gpick_q | (take ? (MASK_W'(1) << cur_ext[NODE_W-1:0]) : '0);
	assign grp_end   = (slot_q == SW'(GS - 1));

	always_comb begin
		low_idx = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (grant_q[i]) begin
				low_idx = NODE_W'(i);
			end
		end
	end

	assign grant_clr = grant_q & (grant_q - MASK_W'(1));
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			avail_q     <= available_mask;
			div_q       <= spread_eff;
			rem_q       <= '0;
			num_q       <= NUM_W'(requested_count) + NUM_W'(spread_eff) - NUM_W'(1);
			div_cnt_q   <= '0;
			remaining_q <= requested_count;
			found_q     <= '0;
			cursor_q    <= '0;
			slot_q      <= '0;
			gpick_q     <= '0;
			grant_q     <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= rem_ge ? SPREAD_W'(rem_sh - {1'b0, div_q}) : rem_sh[SPREAD_W-1:0];
			num_q     <= {num_q[NUM_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end else if (cmd.scan_step) begin
			cursor_q <= cursor_q + CW'(1);
			if (grp_end) begin
				// group gives all it was asked for, or nothing
				if (found_nx == need) begin
					grant_q     <= grant_q | pick_nx;
					remaining_q <= remaining_q - need;
				end
				found_q <= '0;
				gpick_q <= '0;
				slot_q  <= '0;
			end else begin
				found_q <= found_nx;
				gpick_q <= pick_nx;
				slot_q  <= slot_q + SW'(1);
			end
		end else if (cmd.push_node) begin
			grant_q <= grant_clr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_node || cmd.push_report) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_node) begin
			granted_node <= low_idx;
			node_valid   <= 1'b1;
			success      <= 1'b1;
			last         <= (grant_clr == '0);
		end else if (cmd.push_report) begin
			granted_node <= '0;
			node_valid   <= 1'b0;
			success      <= (remaining_q == '0);
			last         <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	assign status.div_done   = (div_cnt_q == DCNT_W'(DIV_STEPS - 1));
	assign status.scan_last  = (cursor_q == CW'(TOTAL - 1));
	assign status.shortfall  = (remaining_q != '0);
	assign status.grant_zero = (grant_q == '0);
	assign status.last_node  = (grant_clr == '0);
	assign status.out_free   = out_free;

	a_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push_node && cmd.push_report))
		else $error("node and report pushed together");

	a_node_needs_grant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_node |-> (grant_q != '0) && (remaining_q == '0) && out_free)
		else $error("node pushed without a full grant");

	a_report_cond: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_report |-> ((remaining_q != '0) || (grant_q == '0)) && out_free)
		else $error("report pushed while nodes are pending");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && status.div_done |=> (rem_q < div_q))
		else $error("divider remainder not below divisor");

	a_remaining_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |=> (remaining_q <= $past(remaining_q)))
		else $error("owed count grew during scan");

endmodule

@@ design/group_striped_node_allocator.sv @@
// Group-striped node allocator.
// Input channel (in_valid/in_ready): one transaction carries requested_count and
// available_mask. in_ready is high only while the block is idle.
// Output channel (out_valid/out_ready): one transaction per granted node, in
// ascending id order, with success=1 and last on the highest id. A shortfall
// gives a single transaction with success=0; a zero request a single one with
// success=1; both have node_valid=0 and last=1.
// Config: group_spread is written on any clock with cfg_wr_en high; the user
// must write it only while idle, which is not enforced. A value of 0 acts as 1.
// Steps per request: accept, restoring quota division, a node-serial group scan
// over every node of the fabric (GROUPS*ROUTERS_PER_GROUP*NODES_PER_ROUTER, 64
// by default), then a decision step that loads a single report transaction on a
// shortfall or zero request, else emits the granted nodes one at a time as the
// output register frees. The node-serial scan sets the bulk of the time taken.
// A stalled receiver holds the output register and pauses result generation;
// the next request is taken once the final result sits in the output register.
// Reset: group_spread returns to 1, the block goes idle, out_valid drops.
module group_striped_node_allocator #(
	parameter int GROUPS            = gsna_pkg::GROUPS_DEF,
	parameter int ROUTERS_PER_GROUP = gsna_pkg::ROUTERS_PER_GROUP_DEF,
	parameter int NODES_PER_ROUTER  = gsna_pkg::NODES_PER_ROUTER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [gsna_pkg::SPREAD_W-1:0] cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gsna_pkg::COUNT_W-1:0]  requested_count,
	input  logic [gsna_pkg::MASK_W-1:0]   available_mask,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gsna_pkg::NODE_W-1:0]   granted_node,
	output logic                          node_valid,
	output logic                          success,
	output logic                          last
);
	import gsna_pkg::*;

	gsna_cmd_t    cmd;
	gsna_status_t status;

	gsna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	gsna_dp #(
		.GROUPS            (GROUPS),
		.ROUTERS_PER_GROUP (ROUTERS_PER_GROUP),
		.NODES_PER_ROUTER  (NODES_PER_ROUTER)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.requested_count (requested_count),
		.available_mask  (available_mask),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.granted_node    (granted_node),
		.node_valid      (node_valid),
		.success         (success),
		.last            (last),
		.cmd             (cmd),
		.status          (status)
	);

endmodule
